// ----- rtl/mbd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mbd_pkg
// Shared types, constants and the channel averaging function of the mip box
// downsampler.
// ----------------------------------------------------------------------------
package mbd_pkg;

   localparam int PIXEL_W         = 32;
   localparam int DEST_WIDTH_W    = 12;
   localparam int DEST_HEIGHT_W   = 16;
   localparam int ROW_W           = 16;
   localparam int MAX_DEST_HEIGHT = 32768;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 16;
   localparam int QUEUE_DEPTH     = 4;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_DEST_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DEST_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_HALVE_X     = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_HALVE_Y     = 2'd3;

   // What the back end does with a horizontal result.
   typedef enum logic [1:0] {
      OP_PASS,
      OP_STORE,
      OP_BLEND
   } op_type;

   // One entry of the queue between front and back end.
   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      op_type             op;
      logic               row_end;
      logic               region_end;
   } entry_type;

   // One finished destination pixel.
   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               row_end;
      logic               region_end;
   } result_type;

   // Per byte channel average of two pixels, truncating.
   function automatic logic [PIXEL_W-1:0] avg_bytes(input logic [PIXEL_W-1:0] a,
                                                    input logic [PIXEL_W-1:0] b);
      logic [PIXEL_W-1:0] r;
      logic [8:0]         s;
      r = '0;
      for (int k = 0; k < 4; k++) begin
         s = {1'b0, a[8*k +: 8]} + {1'b0, b[8*k +: 8]};
         r[8*k +: 8] = s[8:1];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/mbd_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mbd_queue
// Small register queue with occupancy count; depth is a power of two.
// ----------------------------------------------------------------------------
module mbd_queue import mbd_pkg::*; #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty,
   output logic                  full,
   output logic      [CNT_W-1:0] count
);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign count    = count_ff;
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and count updates for each transfer.
   always_comb begin
      wr_ptr_in = do_push ? PTR_W'((32'(wr_ptr_ff) + 1) % DEPTH) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? PTR_W'((32'(rd_ptr_ff) + 1) % DEPTH) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage; no reset needed on payload.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/mbd_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mbd_front
// Accepts source pixels, tracks the source position, pairs pixels
// horizontally and classifies each horizontal result for the back end.
// ----------------------------------------------------------------------------
module mbd_front import mbd_pkg::*; #(
   parameter int MAX_DEST_WIDTH = 2048,
   localparam int IDX_W = (MAX_DEST_WIDTH > 1) ? $clog2(MAX_DEST_WIDTH) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Source pixel channel
   input  wire logic                   accept,
   input  wire logic [PIXEL_W-1:0]     in_pixel,
   // Configuration writes
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   // Towards the middle queue
   output logic                        mid_push,
   output entry_type                   mid_entry,
   output logic      [IDX_W-1:0]       mid_dcol
);

   localparam int DW_W  = $clog2(MAX_DEST_WIDTH + 1);
   localparam int COL_W = $clog2(2 * MAX_DEST_WIDTH);
   localparam int SW_W  = COL_W + 1;
   localparam int SH_W  = ROW_W + 1;

   logic [DW_W-1:0]          dw_ff;
   logic [DEST_HEIGHT_W-1:0] dh_ff;
   logic                     halve_x_ff, halve_y_ff;
   logic [COL_W-1:0]         column_ff, column_in;
   logic [ROW_W-1:0]         row_ff, row_in;
   logic [PIXEL_W-1:0]       pair_hold_ff, pair_hold_in;

   logic [DEST_WIDTH_W-1:0]  wr_width;
   logic [DEST_HEIGHT_W-1:0] wr_height;
   logic [DW_W-1:0]          dw_clamped;
   logic [DEST_HEIGHT_W-1:0] dh_clamped;

   logic [SW_W-1:0]          src_w;
   logic [SH_W-1:0]          src_h;
   logic [COL_W-1:0]         col;
   logic [ROW_W-1:0]         row;
   logic                     last_src_col, last_src_row;
   logic [COL_W-1:0]         dcol;
   logic [ROW_W-1:0]         drow;
   logic                     row_end;

   // Sizes are clamped into range as they are written.
   assign wr_width  = csr_wdata[DEST_WIDTH_W-1:0];
   assign wr_height = csr_wdata[DEST_HEIGHT_W-1:0];

   always_comb begin
      if (wr_width == '0) begin
         dw_clamped = DW_W'(1);
      end else if (32'(wr_width) > 32'(MAX_DEST_WIDTH)) begin
         dw_clamped = DW_W'(MAX_DEST_WIDTH);
      end else begin
         dw_clamped = DW_W'(wr_width);
      end
      if (wr_height == '0) begin
         dh_clamped = DEST_HEIGHT_W'(1);
      end else if (32'(wr_height) > 32'(MAX_DEST_HEIGHT)) begin
         dh_clamped = DEST_HEIGHT_W'(MAX_DEST_HEIGHT);
      end else begin
         dh_clamped = wr_height;
      end
   end

   // Source region size and the current position, saturated into it.
   always_comb begin
      src_w = halve_x_ff ? SW_W'({dw_ff, 1'b0}) : SW_W'(dw_ff);
      src_h = halve_y_ff ? SH_W'({dh_ff, 1'b0}) : SH_W'(dh_ff);
      col   = (SW_W'(column_ff) < src_w) ? column_ff : COL_W'(src_w - SW_W'(1));
      row   = (SH_W'(row_ff) < src_h) ? row_ff : ROW_W'(src_h - SH_W'(1));
      last_src_col = (SW_W'(col) == src_w - SW_W'(1));
      last_src_row = (SH_W'(row) == src_h - SH_W'(1));
      dcol    = halve_x_ff ? (col >> 1) : col;
      drow    = halve_y_ff ? (row >> 1) : row;
      row_end = (SW_W'(dcol) == SW_W'(dw_ff) - SW_W'(1));
   end

   // Classification of the accepted pixel.
   always_comb begin
      pair_hold_in          = pair_hold_ff;
      mid_push              = 1'b0;
      mid_entry.pixel       = in_pixel;
      mid_entry.op          = OP_PASS;
      mid_entry.row_end     = row_end;
      mid_entry.region_end  = row_end && (drow == dh_ff - DEST_HEIGHT_W'(1));
      mid_dcol              = IDX_W'(dcol);
      if (halve_x_ff) begin
         mid_entry.pixel = avg_bytes(pair_hold_ff, in_pixel);
      end
      if (halve_y_ff) begin
         mid_entry.op = row[0] ? OP_BLEND : OP_STORE;
      end
      if (accept) begin
         if (halve_x_ff && !col[0]) begin
            pair_hold_in = in_pixel;
         end else begin
            mid_push = 1'b1;
         end
      end
   end

   // Position stepping on every transfer.
   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (accept) begin
         if (last_src_col) begin
            column_in = '0;
            row_in    = last_src_row ? '0 : row + ROW_W'(1);
         end else begin
            column_in = col + COL_W'(1);
            row_in    = row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dw_ff        <= DW_W'(1);
         dh_ff        <= DEST_HEIGHT_W'(1);
         halve_x_ff   <= 1'b1;
         halve_y_ff   <= 1'b1;
         column_ff    <= '0;
         row_ff       <= '0;
         pair_hold_ff <= '0;
      end else begin
         column_ff    <= column_in;
         row_ff       <= row_in;
         pair_hold_ff <= pair_hold_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_DEST_WIDTH:  dw_ff      <= dw_clamped;
               REG_DEST_HEIGHT: dh_ff      <= dh_clamped;
               REG_HALVE_X:     halve_x_ff <= csr_wdata[0];
               REG_HALVE_Y:     halve_y_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

endmodule
`default_nettype wire

// ----- rtl/mbd_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mbd_back
// Carries out the vertical step: passes results on if rows are not halved, else
// stores even-row results in the line store and averages odd rows with them.
// ----------------------------------------------------------------------------
module mbd_back import mbd_pkg::*; #(
   parameter int MAX_DEST_WIDTH = 2048,
   parameter int OUT_DEPTH      = 4,
   localparam int IDX_W = (MAX_DEST_WIDTH > 1) ? $clog2(MAX_DEST_WIDTH) : 1,
   localparam int CNT_W = $clog2(OUT_DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // From the middle queue
   input  wire logic             mid_empty,
   input  wire entry_type        mid_entry,
   input  wire logic [IDX_W-1:0] mid_dcol,
   output logic                  mid_pop,
   // Towards the result queue
   input  wire logic [CNT_W-1:0] out_count,
   output logic                  out_push,
   output result_type            out_result
);

   logic [PIXEL_W-1:0] line_store [MAX_DEST_WIDTH];
   logic [PIXEL_W-1:0] stored_ff;
   logic               busy_ff;
   entry_type          entry_ff;

   // Issue only when the result queue has room for the item in flight too.
   assign mid_pop = !mid_empty &&
                    ((32'(out_count) + 32'(busy_ff)) < 32'(OUT_DEPTH));

   // Line store: write on even rows, registered read for odd rows.
   always_ff @(posedge clock) begin
      if (mid_pop) begin
         if (mid_entry.op == OP_STORE) begin
            line_store[mid_dcol] <= mid_entry.pixel;
         end
         stored_ff <= line_store[mid_dcol];
      end
   end

   // Stage register beside the memory read.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= mid_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_pop) begin
         entry_ff <= mid_entry;
      end
   end

   // Vertical averaging and result forming.
   always_comb begin
      out_push              = 1'b0;
      out_result.pixel      = entry_ff.pixel;
      out_result.row_end    = entry_ff.row_end;
      out_result.region_end = entry_ff.region_end;
      unique case (entry_ff.op)
         OP_PASS: begin
            out_push = busy_ff;
         end
         OP_BLEND: begin
            out_push         = busy_ff;
            out_result.pixel = avg_bytes(stored_ff, entry_ff.pixel);
         end
         default: begin
            out_push = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- rtl/mip_box_downsampler.sv -----
`default_nettype none
// A result reaches the rsp_ ports through the middle queue, the back end stage
// register and the result queue. Throughput: one source pixel per cycle while
// the middle queue is not full; the back end uses the line store once per entry.
// Reset clears positions, pair hold and queues and restores the register
// defaults; the line store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// mip_box_downsampler
// 2x2 box filter (2x1, 1x2 or 1x1 per halve register) making the next smaller
// mip level of RGBA raster pixels; front and back end joined by a short queue.
// ----------------------------------------------------------------------------
module mip_box_downsampler import mbd_pkg::*; #(
   parameter int MAX_DEST_WIDTH = 2048
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Source pixels
   input  wire logic                   push,
   output logic                        full,
   input  wire logic [PIXEL_W-1:0]     req_in_pixel,
   // Destination pixels
   output logic                        empty,
   input  wire logic                   pop,
   output logic      [PIXEL_W-1:0]     rsp_out_pixel,
   output logic                        rsp_row_end,
   output logic                        rsp_region_end,
   // Configuration
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IDX_W   = (MAX_DEST_WIDTH > 1) ? $clog2(MAX_DEST_WIDTH) : 1;
   localparam int MID_W   = $bits(entry_type) + IDX_W;
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

   logic             accept;
   logic             mid_push, mid_pop, mid_empty;
   entry_type        front_entry, back_entry;
   logic [IDX_W-1:0] front_dcol, back_dcol;
   logic [MID_W-1:0] mid_head;
   logic [CNT_W-1:0] mid_count, out_count;
   logic             out_push, out_full;
   result_type       back_result, head_result;

   assign accept = push && !full;

   // Front end: position tracking and horizontal pairing.
   mbd_front #(
      .MAX_DEST_WIDTH (MAX_DEST_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_pixel  (req_in_pixel),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .mid_push  (mid_push),
      .mid_entry (front_entry),
      .mid_dcol  (front_dcol)
   );

   // Queue between front and back end; its fill state backs up the source.
   mbd_queue #(
      .WIDTH (MID_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data ({front_entry, front_dcol}),
      .pop       (mid_pop),
      .pop_data  (mid_head),
      .empty     (mid_empty),
      .full      (full),
      .count     (mid_count)
   );

   assign back_entry = entry_type'(mid_head[MID_W-1:IDX_W]);
   assign back_dcol  = mid_head[IDX_W-1:0];

   // Back end: line store and vertical averaging.
   mbd_back #(
      .MAX_DEST_WIDTH (MAX_DEST_WIDTH),
      .OUT_DEPTH      (QUEUE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .mid_empty  (mid_empty),
      .mid_entry  (back_entry),
      .mid_dcol   (back_dcol),
      .mid_pop    (mid_pop),
      .out_count  (out_count),
      .out_push   (out_push),
      .out_result (back_result)
   );

   // Result queue; the back end only issues when there is room.
   mbd_queue #(
      .WIDTH ($bits(result_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push && !(out_full && mid_count == '1)),
      .push_data (back_result),
      .pop       (pop),
      .pop_data  (head_result),
      .empty     (empty),
      .full      (out_full),
      .count     (out_count)
   );

   assign rsp_out_pixel  = head_result.pixel;
   assign rsp_row_end    = head_result.row_end;
   assign rsp_region_end = head_result.region_end;

endmodule
`default_nettype wire
